/* rtl/mgrc_pkg.sv */
`default_nettype none

package mgrc_pkg;

    // Field widths
    localparam int MAG_W   = 16;
    localparam int VAR_W   = 16;
    localparam int STAMP_W = 32;
    localparam int RUN_W   = 8;
    localparam int REPS_W  = 16;
    localparam int PHASE_W = 2;

    // Stream widths, padded to whole bytes
    localparam int IN_W     = MAG_W + VAR_W + STAMP_W;
    localparam int RES_W    = REPS_W + 1 + 1 + PHASE_W + 1 + STAMP_W + STAMP_W;
    localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD  = OUT_W - RES_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VAR_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_ON_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_OFF_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TROUGH_LEVEL     = 3'd4;

    // Configuration reset values
    localparam logic [VAR_W-1:0] VAR_THRESHOLD_RST    = 16'd64;
    localparam logic [RUN_W-1:0] MOTION_ON_COUNT_RST  = 8'd10;
    localparam logic [RUN_W-1:0] MOTION_OFF_COUNT_RST = 8'd5;
    localparam logic signed [MAG_W-1:0] PEAK_LEVEL_RST   = 16'sd115;
    localparam logic signed [MAG_W-1:0] TROUGH_LEVEL_RST = -16'sd115;

    // Rep phase codes
    localparam logic [PHASE_W-1:0] PH_WAIT_PEAK   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_TROUGH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_PEAK2  = 2'd2;

    localparam logic [RUN_W-1:0]  RUN_MAX  = '1;
    localparam logic [REPS_W-1:0] REPS_MAX = '1;

    // One input sample
    typedef struct packed {
        logic [STAMP_W-1:0]      stamp_ms;
        logic [VAR_W-1:0]        variance;
        logic signed [MAG_W-1:0] magnitude;
    } mgrc_sample_t;

    // One result, last field in the low bits
    typedef struct packed {
        logic [STAMP_W-1:0] interval_end_ms;
        logic [STAMP_W-1:0] interval_start_ms;
        logic               interval_done;
        logic [PHASE_W-1:0] phase;
        logic               moving;
        logic               rep_done;
        logic [REPS_W-1:0]  reps;
    } mgrc_result_t;

endpackage

`default_nettype wire

/* rtl/motion_gated_rep_counter_unit.sv */
`default_nettype none

// Channel   Dir  Payload                                         Handshake
// s_axis    in   magnitude, variance, stamp_ms                   tvalid/tready
// m_axis    out  reps, rep_done, moving, phase, interval_done,   tvalid/tready
//                interval_start_ms, interval_end_ms
// cfg       in   cfg_index, cfg_data                             cfg_valid/cfg_ready
//
// Two register stages: an input register, then the result register. One sample
// is taken every cycle unless a stall on m_axis holds the stages.
// The motion/rep state updates when a sample moves into the result register,
// so the next sample in the input register already sees it.
// A stall on m_axis holds both stages; the input stage still fills while
// the result waits. rst_n clears all control state and loads register defaults.
// cfg_ready is always high.

module motion_gated_rep_counter_unit
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] magnitude, [31:16] variance, [63:32] stamp_ms
    input  wire logic [mgrc_pkg::IN_W-1:0]      s_axis_tdata,

    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] reps, [16] rep_done, [17] moving, [19:18] phase,
    // [20] interval_done, [52:21] interval_start_ms, [84:53] interval_end_ms
    output logic [mgrc_pkg::OUT_W-1:0]          m_axis_tdata,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mgrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mgrc_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mgrc_pkg::*;

    // Configuration registers
    logic [VAR_W-1:0]        var_threshold_reg;
    logic [RUN_W-1:0]        motion_on_count_reg;
    logic [RUN_W-1:0]        motion_off_count_reg;
    logic signed [MAG_W-1:0] peak_level_reg;
    logic signed [MAG_W-1:0] trough_level_reg;

    // Pipeline registers
    logic         in_valid_reg;
    mgrc_sample_t in_sample_reg;
    logic         out_valid_reg;
    mgrc_result_t out_result_reg;

    // Block state
    logic                    motion_flag_reg,  motion_flag_next;
    logic [RUN_W-1:0]        above_run_reg,    above_run_next;
    logic [RUN_W-1:0]        below_run_reg,    below_run_next;
    logic [PHASE_W-1:0]      rep_phase_reg,    rep_phase_next;
    logic [REPS_W-1:0]       rep_total_reg,    rep_total_next;
    logic signed [MAG_W-1:0] last_sample_reg;
    logic signed [MAG_W-1:0] older_sample_reg;
    logic [STAMP_W-1:0]      motion_begin_reg, motion_begin_next;
    logic [STAMP_W-1:0]      peak_time_reg,    peak_time_next;
    logic [STAMP_W-1:0]      trough_time_reg,  trough_time_next;

    mgrc_result_t result_next;

    logic out_free;
    logic advance;
    logic is_max;
    logic is_min;

    // Handshake: result register frees on take, input stage moves when it is free
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_result_reg};
    assign cfg_ready     = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_threshold_reg    <= VAR_THRESHOLD_RST;
            motion_on_count_reg  <= MOTION_ON_COUNT_RST;
            motion_off_count_reg <= MOTION_OFF_COUNT_RST;
            peak_level_reg       <= PEAK_LEVEL_RST;
            trough_level_reg     <= TROUGH_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VAR_THRESHOLD:    var_threshold_reg    <= cfg_data;
                REG_MOTION_ON_COUNT:  motion_on_count_reg  <= cfg_data[RUN_W-1:0];
                REG_MOTION_OFF_COUNT: motion_off_count_reg <= cfg_data[RUN_W-1:0];
                REG_PEAK_LEVEL:       peak_level_reg       <= cfg_data;
                REG_TROUGH_LEVEL:     trough_level_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Local extremum of the previous sample
    assign is_max = (last_sample_reg > older_sample_reg) &&
                    (last_sample_reg > in_sample_reg.magnitude);
    assign is_min = (last_sample_reg < older_sample_reg) &&
                    (last_sample_reg < in_sample_reg.magnitude);

    // Motion gate and rep phase machine
    always_comb
    begin
        motion_flag_next  = motion_flag_reg;
        above_run_next    = above_run_reg;
        below_run_next    = below_run_reg;
        rep_phase_next    = rep_phase_reg;
        rep_total_next    = rep_total_reg;
        motion_begin_next = motion_begin_reg;
        peak_time_next    = peak_time_reg;
        trough_time_next  = trough_time_reg;

        result_next                   = '0;

        // run counters, saturating
        if (!motion_flag_reg)
        begin
            if (in_sample_reg.variance > var_threshold_reg)
                above_run_next = (above_run_reg == RUN_MAX) ? RUN_MAX
                                                            : above_run_reg + 1'b1;
            else
                above_run_next = '0;
            if (above_run_next >= motion_on_count_reg)
            begin
                motion_begin_next = in_sample_reg.stamp_ms;
                motion_flag_next  = 1'b1;
                above_run_next    = '0;
            end
        end
        else
        begin
            if (in_sample_reg.variance < var_threshold_reg)
                below_run_next = (below_run_reg == RUN_MAX) ? RUN_MAX
                                                            : below_run_reg + 1'b1;
            else
                below_run_next = '0;
            if (below_run_next >= motion_off_count_reg)
            begin
                result_next.interval_done     = 1'b1;
                result_next.interval_start_ms = motion_begin_reg;
                result_next.interval_end_ms   = in_sample_reg.stamp_ms;
                motion_flag_next              = 1'b0;
                below_run_next                = '0;
            end
        end

        // peak / trough / peak sequence
        priority if (!motion_flag_next)
        begin
            rep_phase_next = PH_WAIT_PEAK;
        end
        else if (rep_phase_reg == PH_WAIT_PEAK && is_max && last_sample_reg > peak_level_reg)
        begin
            peak_time_next = in_sample_reg.stamp_ms;
            rep_phase_next = PH_WAIT_TROUGH;
        end
        else if (rep_phase_reg == PH_WAIT_TROUGH && is_min &&
                 last_sample_reg < trough_level_reg)
        begin
            trough_time_next = in_sample_reg.stamp_ms;
            rep_phase_next   = PH_WAIT_PEAK2;
        end
        else if (rep_phase_reg == PH_WAIT_PEAK2 && is_max && last_sample_reg > peak_level_reg)
        begin
            if (trough_time_reg > peak_time_reg && in_sample_reg.stamp_ms > trough_time_reg)
            begin
                result_next.rep_done = 1'b1;
                if (rep_total_reg != REPS_MAX)
                    rep_total_next = rep_total_reg + 1'b1;
            end
            rep_phase_next = PH_WAIT_PEAK;
        end
        else
        begin
            // no qualifying extremum: phase holds
        end

        result_next.reps   = rep_total_next;
        result_next.moving = motion_flag_next;
        result_next.phase  = rep_phase_next;
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_sample_reg <= s_axis_tdata;
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= result_next;
    end

    // State update on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_flag_reg  <= 1'b0;
            above_run_reg    <= '0;
            below_run_reg    <= '0;
            rep_phase_reg    <= PH_WAIT_PEAK;
            rep_total_reg    <= '0;
            last_sample_reg  <= '0;
            older_sample_reg <= '0;
            motion_begin_reg <= '0;
            peak_time_reg    <= '0;
            trough_time_reg  <= '0;
        end
        else if (advance)
        begin
            motion_flag_reg  <= motion_flag_next;
            above_run_reg    <= above_run_next;
            below_run_reg    <= below_run_next;
            rep_phase_reg    <= rep_phase_next;
            rep_total_reg    <= rep_total_next;
            older_sample_reg <= last_sample_reg;
            last_sample_reg  <= in_sample_reg.magnitude;
            motion_begin_reg <= motion_begin_next;
            peak_time_reg    <= peak_time_next;
            trough_time_reg  <= trough_time_next;
        end
    end

endmodule

`default_nettype wire

/* bench/rep_counter_checker.sv */
`default_nettype none

module rep_counter_checker
    import mgrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]       s_axis_tdata,

    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_W-1:0]      m_axis_tdata,

    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    output int                         mismatches,
    output int                         reports_due
);

    // register copies
    logic [VAR_W-1:0]        thr;
    logic [RUN_W-1:0]        on_cnt;
    logic [RUN_W-1:0]        off_cnt;
    logic signed [MAG_W-1:0] peak_lvl;
    logic signed [MAG_W-1:0] trough_lvl;

    // motion / rep state
    logic                    moving_q;
    logic [RUN_W-1:0]        above_run;
    logic [RUN_W-1:0]        below_run;
    logic [PHASE_W-1:0]      phase_q;
    logic [REPS_W-1:0]       reps_q;
    logic signed [MAG_W-1:0] prev_mag;
    logic signed [MAG_W-1:0] prev2_mag;
    logic [STAMP_W-1:0]      begin_ms;
    logic [STAMP_W-1:0]      peak_ms;
    logic [STAMP_W-1:0]      trough_ms;

    // predicted reports, oldest first
    mgrc_result_t            rep_reports[$];
    mgrc_result_t            want;
    mgrc_result_t            seen;

    // Advance the motion gate and the rep phase machine by one sample
    function automatic mgrc_result_t count_reps_step(mgrc_sample_t smp);
        mgrc_result_t            r;
        logic signed [MAG_W-1:0] mag;
        logic                    is_max;
        logic                    is_min;
        r   = '0;
        mag = smp.magnitude;

        // motion gate
        if (!moving_q) begin
            if (smp.variance > thr)
                above_run = (above_run != RUN_MAX) ? above_run + 1'b1 : RUN_MAX;
            else
                above_run = '0;
            if (above_run >= on_cnt) begin
                begin_ms  = smp.stamp_ms;
                moving_q  = 1'b1;
                above_run = '0;
            end
        end
        else begin
            if (smp.variance < thr)
                below_run = (below_run != RUN_MAX) ? below_run + 1'b1 : RUN_MAX;
            else
                below_run = '0;
            if (below_run >= off_cnt) begin
                r.interval_done     = 1'b1;
                r.interval_start_ms = begin_ms;
                r.interval_end_ms   = smp.stamp_ms;
                moving_q            = 1'b0;
                below_run           = '0;
            end
        end

        // extremum on the previous sample
        is_max = (prev_mag > prev2_mag) && (prev_mag > mag);
        is_min = (prev_mag < prev2_mag) && (prev_mag < mag);

        if (!moving_q)
            phase_q = PH_WAIT_PEAK;
        else if (phase_q == PH_WAIT_PEAK && is_max && prev_mag > peak_lvl) begin
            peak_ms = smp.stamp_ms;
            phase_q = PH_WAIT_TROUGH;
        end
        else if (phase_q == PH_WAIT_TROUGH && is_min && prev_mag < trough_lvl) begin
            trough_ms = smp.stamp_ms;
            phase_q   = PH_WAIT_PEAK2;
        end
        else if (phase_q == PH_WAIT_PEAK2 && is_max && prev_mag > peak_lvl) begin
            // out-of-order stamps still close the cycle, without a count
            if (trough_ms > peak_ms && smp.stamp_ms > trough_ms) begin
                r.rep_done = 1'b1;
                if (reps_q != REPS_MAX)
                    reps_q = reps_q + 1'b1;
            end
            phase_q = PH_WAIT_PEAK;
        end

        prev2_mag = prev_mag;
        prev_mag  = mag;

        r.reps   = reps_q;
        r.moving = moving_q;
        r.phase  = phase_q;
        return r;
    endfunction

    task automatic compare_field(string name, logic [STAMP_W-1:0] exp_v,
                                 logic [STAMP_W-1:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    // Track config writes, compare results, predict on accepted samples
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr         = VAR_THRESHOLD_RST;
            on_cnt      = MOTION_ON_COUNT_RST;
            off_cnt     = MOTION_OFF_COUNT_RST;
            peak_lvl    = PEAK_LEVEL_RST;
            trough_lvl  = TROUGH_LEVEL_RST;
            moving_q    = 1'b0;
            above_run   = '0;
            below_run   = '0;
            phase_q     = PH_WAIT_PEAK;
            reps_q      = '0;
            prev_mag    = '0;
            prev2_mag   = '0;
            begin_ms    = '0;
            peak_ms     = '0;
            trough_ms   = '0;
            rep_reports.delete();
            mismatches  = 0;
            reports_due = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VAR_THRESHOLD:    thr        = cfg_data;
                    REG_MOTION_ON_COUNT:  on_cnt     = cfg_data[RUN_W-1:0];
                    REG_MOTION_OFF_COUNT: off_cnt    = cfg_data[RUN_W-1:0];
                    REG_PEAK_LEVEL:       peak_lvl   = cfg_data;
                    REG_TROUGH_LEVEL:     trough_lvl = cfg_data;
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata[RES_W-1:0];
                if (rep_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected nothing, got %h",
                             $time, seen);
                end
                else begin
                    want = rep_reports.pop_front();
                    compare_field("reps", want.reps, seen.reps);
                    compare_field("rep_done", want.rep_done, seen.rep_done);
                    compare_field("moving", want.moving, seen.moving);
                    compare_field("phase", want.phase, seen.phase);
                    compare_field("interval_done", want.interval_done, seen.interval_done);
                    compare_field("interval_start_ms", want.interval_start_ms,
                                  seen.interval_start_ms);
                    compare_field("interval_end_ms", want.interval_end_ms,
                                  seen.interval_end_ms);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                rep_reports.push_back(count_reps_step(mgrc_sample_t'(s_axis_tdata)));

            reports_due = rep_reports.size();
        end
    end

endmodule

`default_nettype wire

/* bench/tb_motion_gated_rep_counter_unit.sv */
`default_nettype none

module tb_motion_gated_rep_counter_unit;
    import mgrc_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int FULL_RATE_REPS = 15;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_W-1:0]         s_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_W-1:0]        m_axis_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int                      mismatches;
    int                      reports_due;
    int                      sent;
    int                      quiet;
    bit                      gaps_on;
    bit                      stalls_on;

    // settings currently loaded, used to shape the samples
    logic [VAR_W-1:0]        cur_thr;
    logic [RUN_W-1:0]        cur_on;
    logic [RUN_W-1:0]        cur_off;
    logic signed [MAG_W-1:0] cur_peak;
    logic signed [MAG_W-1:0] cur_trough;
    logic [STAMP_W-1:0]      now_ms;

    motion_gated_rep_counter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rep_counter_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .reports_due   (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side backpressure
    always @(negedge clk)
    begin
        m_axis_tready <= !stalls_on || ($urandom_range(99) >= 25);
    end

    // Watchdog: too long without any handshake
    initial
    begin
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_motion_gated_rep_counter_unit failed");
        $finish;
    end

    // Mostly rising stamps, sometimes repeated or stepping back
    function automatic logic [STAMP_W-1:0] tick_ms();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            now_ms = now_ms - $urandom_range(30, 1);
        else if (r >= 5)
            now_ms = now_ms + $urandom_range(20, 1);
        return now_ms;
    endfunction

    function automatic logic [VAR_W-1:0] var_above();
        if (cur_thr == '1)
            return '1;
        return VAR_W'($urandom_range(32'(cur_thr) + 1, 65535));
    endfunction

    function automatic logic [VAR_W-1:0] var_below();
        if (cur_thr == '0)
            return '0;
        return VAR_W'($urandom_range(0, 32'(cur_thr) - 1));
    endfunction

    // variance while in motion: mostly above, sometimes equal or below
    function automatic logic [VAR_W-1:0] var_moving();
        int r;
        r = $urandom_range(99);
        if (r < 88)
            return var_above();
        else if (r < 94)
            return cur_thr;
        return var_below();
    endfunction

    function automatic logic signed [MAG_W-1:0] peak_mag();
        int v;
        v = int'(cur_peak) + int'($urandom_range(300, 1));
        if (v > 32767)
            v = 32767;
        return v[MAG_W-1:0];
    endfunction

    function automatic logic signed [MAG_W-1:0] trough_mag();
        int v;
        v = int'(cur_trough) - int'($urandom_range(300, 1));
        if (v < -32768)
            v = -32768;
        return v[MAG_W-1:0];
    endfunction

    function automatic logic signed [MAG_W-1:0] quiet_mag();
        int v;
        v = int'($urandom_range(64)) - 32;
        return v[MAG_W-1:0];
    endfunction

    // One sample request; returns at the falling edge after acceptance
    task automatic send(input logic signed [MAG_W-1:0] mag, input logic [VAR_W-1:0] vr,
                        input logic [STAMP_W-1:0] stamp);
        while (gaps_on && $urandom_range(99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {stamp, vr, mag};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    // Hold off the sender until every result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load all registers; only called with the block drained
    task automatic set_config(input logic [VAR_W-1:0] thr, input logic [RUN_W-1:0] on_c,
                              input logic [RUN_W-1:0] off_c,
                              input logic signed [MAG_W-1:0] pk,
                              input logic signed [MAG_W-1:0] tr);
        write_reg(REG_VAR_THRESHOLD, thr);
        write_reg(REG_MOTION_ON_COUNT, {8'h00, on_c});
        write_reg(REG_MOTION_OFF_COUNT, {8'h00, off_c});
        write_reg(REG_PEAK_LEVEL, pk);
        write_reg(REG_TROUGH_LEVEL, tr);
        cfg_valid  <= 1'b0;
        cur_thr    = thr;
        cur_on     = on_c;
        cur_off    = off_c;
        cur_peak   = pk;
        cur_trough = tr;
    endtask

    // Enter motion, swing through a few reps, then settle back to rest
    task automatic session();
        int swings;
        swings = 2 * $urandom_range(5, 1) + 1;
        repeat (cur_on) send(quiet_mag(), var_above(), tick_ms());
        for (int i = 0; i < swings; i++)
        begin
            if ($urandom_range(99) < 10)
                send(quiet_mag(), var_moving(), tick_ms());
            send((i % 2 == 0) ? peak_mag() : trough_mag(), var_moving(), tick_ms());
        end
        repeat (cur_off) send(quiet_mag(), var_below(), tick_ms());
    endtask

    task automatic noise();
        logic [VAR_W-1:0] vr;
        vr = ($urandom_range(99) < 15) ? cur_thr : VAR_W'($urandom);
        send(MAG_W'($urandom), vr, ($urandom_range(1) != 0) ? tick_ms() : $urandom);
    endtask

    task automatic random_phase(input int target);
        int stop;
        int r;
        stop = sent + target;
        while (sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 70)
                session();
            else if (r < 98)
                repeat ($urandom_range(8, 1)) noise();
            else
                drain();
        end
        drain();
    endtask

    // Stimulus
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_VAR_THRESHOLD;
        cfg_data      = '0;
        sent          = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        now_ms        = 32'd100;
        cur_thr       = VAR_THRESHOLD_RST;
        cur_on        = MOTION_ON_COUNT_RST;
        cur_off       = MOTION_OFF_COUNT_RST;
        cur_peak      = PEAK_LEVEL_RST;
        cur_trough    = TROUGH_LEVEL_RST;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // field extremes, variance equal to the threshold, one reset-default interval
        send(16'sh7FFF, 16'hFFFF, 32'h0000_0000);
        send(-16'sh8000, 16'h0000, 32'hFFFF_FFFF);
        send(16'sh0000, 16'd64, 32'd1);
        send(16'sh0001, 16'd65, 32'd2);
        for (int i = 0; i < 14; i++)
        begin
            case (i % 4)
                0: send(16'sh0000, 16'd65 + 16'(i), 32'd10 + 32'(i));
                1: send(16'sh012C, 16'd65 + 16'(i), 32'd10 + 32'(i));
                2: send(16'sh0000, 16'd65 + 16'(i), 32'd10 + 32'(i));
                default: send(-16'sh012C, 16'd65 + 16'(i), 32'd10 + 32'(i));
            endcase
        end
        repeat (5) send(16'sh0000, 16'd63, tick_ms());
        drain();

        random_phase(80);

        // lowest threshold, runs of one, levels no sample can pass
        set_config(16'h0000, 8'd1, 8'd1, 16'sh7FFF, -16'sh8000);
        random_phase(50);

        // threshold that no variance exceeds
        set_config(16'hFFFF, 8'd1, 8'd1, 16'sh0073, -16'sh0073);
        random_phase(30);

        // longest runs: one full session
        set_config(16'h0800, 8'd255, 8'd255, 16'sh0100, -16'sh0100);
        session();
        drain();

        // zero run counts: met at once
        set_config(16'd300, 8'd0, 8'd0, 16'sh0073, -16'sh0073);
        random_phase(50);

        // levels every extremum passes
        set_config(16'd300, 8'd2, 8'd3, -16'sh8000, 16'sh7FFF);
        random_phase(60);

        repeat (2)
        begin
            set_config(VAR_W'($urandom), RUN_W'($urandom_range(12, 1)),
                       RUN_W'($urandom_range(12, 1)), MAG_W'($urandom_range(2000)),
                       MAG_W'(-int'($urandom_range(2000))));
            random_phase(50);
        end

        // full-rate stretch of back-to-back reps
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_config(16'd100, 8'd1, 8'd255, 16'sh0100, -16'sh0100);
        now_ms = 32'd0;
        send(16'sh0000, 16'hFFFF, now_ms);
        repeat (FULL_RATE_REPS)
        begin
            for (int k = 0; k < 4; k++)
            begin
                now_ms = now_ms + 1;
                send((k % 2 == 0) ? 16'sh0400 : -16'sh0400, 16'hFFFF, now_ms);
            end
        end
        drain();

        // back to defaults
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_config(VAR_THRESHOLD_RST, MOTION_ON_COUNT_RST, MOTION_OFF_COUNT_RST,
                   PEAK_LEVEL_RST, TROUGH_LEVEL_RST);
        random_phase(50);

        if (mismatches == 0 && reports_due == 0)
            $display("tb_motion_gated_rep_counter_unit passed");
        else
            $display("tb_motion_gated_rep_counter_unit failed");
        $finish;
    end

endmodule

`default_nettype wire
